// ===== hw/rtl/x86prf_pkg.sv =====
`default_nettype none
package x86prf_pkg;

  localparam int NUM_REGS  = 17;
  localparam int IDX_IN_W  = 5;
  localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int DATA_W    = 64;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_UNKNOWN = 2'd2;

  localparam logic [2:0] SZ_LOW8  = 3'd0;
  localparam logic [2:0] SZ_HIGH8 = 3'd1;
  localparam logic [2:0] SZ_WORD  = 3'd2;
  localparam logic [2:0] SZ_DWORD = 3'd3;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [IDX_IN_W-1:0] reg_index;
    logic [2:0]          size_code;
    logic [DATA_W-1:0]   write_value;
  } req_t;

  typedef struct packed {
    logic              read_ok;
    logic [DATA_W-1:0] read_value;
  } res_t;

  typedef struct packed {
    logic [1:0]           op;
    logic                 hit;
    logic [REG_IDX_W-1:0] idx;
    logic [2:0]           size;
    logic [DATA_W-1:0]    mask;
    logic [DATA_W-1:0]    data;
  } cmd_t;

  function automatic logic [DATA_W-1:0] slice_mask(input logic [2:0] size);
    logic [DATA_W-1:0] m;
    case (size)
      SZ_LOW8:  m = 64'h0000_0000_0000_00FF;
      SZ_WORD:  m = 64'h0000_0000_0000_FFFF;
      SZ_DWORD: m = 64'h0000_0000_FFFF_FFFF;
      default:  m = '1;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/x86prf_front.sv =====
`default_nettype none
module x86prf_front (
  input  wire logic              start,
  input  wire logic              busy,
  input  wire x86prf_pkg::req_t  req,
  output logic                   push,
  output x86prf_pkg::cmd_t       cmd
);
  import x86prf_pkg::*;

  logic mapped;
  logic [DATA_W-1:0] m;
  logic [DATA_W-1:0] d;

  assign mapped = (req.reg_index < IDX_IN_W'(NUM_REGS));

  always_comb begin
    case (req.size_code)
      SZ_LOW8: begin
        m = 64'h0000_0000_0000_00FF;
        d = req.write_value;
      end
      SZ_HIGH8: begin
        m = 64'h0000_0000_0000_FF00;
        d = {48'd0, req.write_value[7:0], 8'd0};
      end
      SZ_WORD: begin
        m = 64'h0000_0000_0000_FFFF;
        d = req.write_value;
      end
      SZ_DWORD: begin
        m = '1;
        d = {32'd0, req.write_value[31:0]};
      end
      default: begin
        m = '1;
        d = req.write_value;
      end
    endcase
  end

  // unmapped writes/marks and unused types are dropped here
  always_comb begin
    case (req.req_type)
      REQ_READ:    push = start && !busy;
      REQ_WRITE:   push = start && !busy && mapped;
      REQ_UNKNOWN: push = start && !busy && mapped;
      default:     push = 1'b0;
    endcase
  end

  assign cmd.op   = req.req_type;
  assign cmd.hit  = mapped;
  assign cmd.idx  = req.reg_index[REG_IDX_W-1:0];
  assign cmd.size = req.size_code;
  assign cmd.mask = m;
  assign cmd.data = d;

endmodule
`default_nettype wire

// ===== hw/rtl/x86prf_queue.sv =====
`default_nettype none
module x86prf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire x86prf_pkg::cmd_t push_cmd,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output x86prf_pkg::cmd_t      head
);
  import x86prf_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/x86prf_back.sv =====
`default_nettype none
module x86prf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid,
  input  wire x86prf_pkg::cmd_t cmd,
  output logic                  done,
  output x86prf_pkg::res_t      result
);
  import x86prf_pkg::*;

  logic [DATA_W-1:0]   vals [NUM_REGS];
  logic [NUM_REGS-1:0] known;
  logic                cur_known;
  logic [DATA_W-1:0]   cur_val;
  logic [DATA_W-1:0]   old_val;
  logic [DATA_W-1:0]   merged;
  logic [DATA_W-1:0]   rd_slice;

  assign cur_known = cmd.hit && known[cmd.idx];
  assign cur_val   = vals[cmd.idx];
  assign old_val   = cur_known ? cur_val : '0;
  assign merged    = (old_val & ~cmd.mask) | (cmd.data & cmd.mask);
  assign rd_slice  = (cmd.size == SZ_HIGH8) ? {56'd0, cur_val[15:8]}
                                            : (cur_val & slice_mask(cmd.size));

  always_ff @(posedge clk) begin
    if (rst) begin
      known <= '0;
      done  <= 1'b0;
    end else begin
      done <= valid && (cmd.op == OP_READ);
      if (valid && cmd.hit) begin
        case (cmd.op)
          OP_WRITE: known[cmd.idx] <= 1'b1;
          OP_CLEAR: known[cmd.idx] <= 1'b0;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid && cmd.hit && (cmd.op == OP_WRITE)) vals[cmd.idx] <= merged;
  end

  always_ff @(posedge clk) begin
    if (valid && (cmd.op == OP_READ)) begin
      result.read_ok    <= cur_known;
      result.read_value <= cur_known ? rd_slice : '0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/x86_partial_register_file.sv =====
// channel  | handshake              | payload
// request  | start & !busy          | req    (req_type, reg_index, size_code, write_value)
// result   | done, one cycle strobe | result (read_ok, read_value)
//
// A beat enters a 2-entry queue the cycle it is taken; the back end retires
// one queued beat per cycle; a read result passes the queue slot, then the result register.
// Sustained rate is one beat per cycle, set by the single register file port.
// busy rises only while the queue is full. Reset clears known bits and queue;
// values are undefined until written. The result side cannot stall.
`default_nettype none
module x86_partial_register_file (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire x86prf_pkg::req_t req,
  output logic                  done,
  output x86prf_pkg::res_t      result
);
  import x86prf_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_head;

  x86prf_front u_front (
    .start (start),
    .busy  (busy),
    .req   (req),
    .push  (push),
    .cmd   (push_cmd)
  );

  x86prf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_valid),
    .full      (busy),
    .not_empty (q_valid),
    .head      (q_head)
  );

  x86prf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .valid  (q_valid),
    .cmd    (q_head),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire
